// ===== design/sct_pkg.sv =====
// constants, types and the rom fill function for the table-plus-taylor sine/cosine unit
`timescale 1ns / 1ps

package sct_pkg;

	// 2^32 / (2*pi), rounded: radians in q8.24 to turns in q0.32 after >> 24
	localparam logic signed [30:0] TURN_K = 31'sd683565276;

	// pi/2 in q0.32 and in q2.30
	localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// output range, signed q2.16
	localparam logic signed [17:0] OUT_MAX = 18'sd131071;
	localparam logic signed [17:0] OUT_MIN = -18'sd131072;

	// taylor series denominators (2k)(2k+1) for k = 1..12
	localparam int unsigned TAYLOR_TERMS = 12;
	localparam logic [63:0] TAYLOR_DIV [0:TAYLOR_TERMS-1] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	typedef logic [16:0]        rom_word_t;
	typedef logic signed [17:0] samp_t;

	// sine of x (radians, q2.30) rounded half up to q1.16, clamped to [0, 65536]
	function automatic rom_word_t rom_sine(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        rnd;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (int unsigned k = 0; k < TAYLOR_TERMS; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k[3:0]];
			if (k[0] == 1'b0) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		rnd = ($unsigned(sum) + 64'd8192) >> 14;
		if (rnd > 64'd65536) begin
			rnd = 64'd65536;
		end
		return rom_word_t'(rnd);
	endfunction

endpackage

// ===== design/sincos_table_taylor_unit.sv =====
// sine/cosine unit: quarter-wave sine rom with second-order taylor correction
`timescale 1ns / 1ps

// channel   signals                        payload
// --------  -----------------------------  ------------------------------------------
// input     in_valid, in_ready             angle   signed q8.24 radians, 32 bits
// output    out_valid, out_ready           sine    signed q2.16, 18 bits
//                                          cosine  signed q2.16, 18 bits
//
// one request per clock sustained while out_ready is high. the unit is a
// seven-stage pipeline around the two-port rom read (stage 3) and the
// multiplier stages on either side of it.
// each stage holds only while it is full and the stage after it holds, so
// bubbles close up and requests keep entering while a result waits at the output.
// reset clears the valid bits only; the rom contents are fixed and need no fill.

module sincos_table_taylor_unit import sct_pkg::*; #(
	parameter int unsigned QUARTER_ENTRIES = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] sine,
	output logic signed [17:0] cosine
);

	// full-circle index width, rom address width
	localparam int FULL_W = $clog2(4 * QUARTER_ENTRIES);
	localparam int IDX_W  = $clog2(QUARTER_ENTRIES + 1);

	// rom step in radians, q0.32, and the widths of h and g
	localparam logic [63:0] STEP_Q32 = HALF_PI_Q32 / 64'(QUARTER_ENTRIES);
	localparam int STEP_W = $clog2(STEP_Q32 + 64'd1);
	localparam int G_W    = 2 * STEP_W - 33;

	// q4.48 accumulation width
	localparam int SUM_W = 52;

	localparam int unsigned STAGES = 7;

	localparam logic [FULL_W:0]     SCALE  = (FULL_W + 1)'(4 * QUARTER_ENTRIES);
	localparam logic [FULL_W-1:0]   QB1    = FULL_W'(QUARTER_ENTRIES);
	localparam logic [FULL_W-1:0]   QB2    = FULL_W'(2 * QUARTER_ENTRIES);
	localparam logic [FULL_W-1:0]   QB3    = FULL_W'(3 * QUARTER_ENTRIES);
	localparam logic [IDX_W-1:0]    QTOP   = IDX_W'(QUARTER_ENTRIES);
	localparam logic [STEP_W-1:0]   STEP_K = STEP_W'(STEP_Q32);
	localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(64'h0000_0000_8000_0000);

	// quarter-wave sine rom, q1.16, entries 0..QUARTER_ENTRIES
	rom_word_t rom_mem [0:QUARTER_ENTRIES];

	for (genvar gi = 0; gi <= QUARTER_ENTRIES; gi++) begin : g_rom
		localparam logic [63:0] X_Q30 = (HALF_PI_Q30 * 64'(gi)) / 64'(QUARTER_ENTRIES);
		assign rom_mem[gi] = rom_sine(X_Q30);
	end

	// pipeline occupancy and advance
	logic [STAGES:1] vld_q;
	logic [STAGES:1] adv;

	always_comb begin
		adv[STAGES] = !vld_q[STAGES] || out_ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_q[STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: radians to turns
	logic signed [61:0] turn_prod_c;
	logic [31:0]        turn_s1;

	assign turn_prod_c = angle * TURN_K;

	// stage 2: turns to quadrant, rom index and step fraction
	logic [32+FULL_W-1:0] scaled_c;
	logic [FULL_W-1:0]    full_c;
	logic [1:0]           quad_c;
	logic [IDX_W-1:0]     idx_c;
	logic [1:0]           quad_s2;
	logic [IDX_W-1:0]     idx_s2;
	logic [31:0]          frac_s2;

	assign scaled_c = turn_s1 * SCALE;
	assign full_c   = scaled_c[32+FULL_W-1:32];

	always_comb begin
		if (full_c >= QB3) begin
			quad_c = 2'd3;
			idx_c  = IDX_W'(full_c - QB3);
		end else if (full_c >= QB2) begin
			quad_c = 2'd2;
			idx_c  = IDX_W'(full_c - QB2);
		end else if (full_c >= QB1) begin
			quad_c = 2'd1;
			idx_c  = IDX_W'(full_c - QB1);
		end else begin
			quad_c = 2'd0;
			idx_c  = IDX_W'(full_c);
		end
	end

	// stage 3: rom read at both addresses, offset h in radians
	logic [32+STEP_W-1:0] h_prod_c;
	rom_word_t            vs_s3;
	rom_word_t            vc_s3;
	logic [STEP_W-1:0]    h_s3;
	logic [1:0]           quad_s3;

	assign h_prod_c = frac_s2 * STEP_K;

	// stage 4: quadrant rotation and g = h*h/2
	logic [2*STEP_W-1:0] h_sq_c;
	samp_t               vs_c;
	samp_t               vc_c;
	samp_t               s0_c;
	samp_t               c0_c;
	samp_t               s0_s4;
	samp_t               c0_s4;
	logic [STEP_W-1:0]   h_s4;
	logic [G_W-1:0]      g_s4;

	assign h_sq_c = h_s3 * h_s3;
	assign vs_c   = $signed({1'b0, vs_s3});
	assign vc_c   = $signed({1'b0, vc_s3});

	always_comb begin
		case (quad_s3)
			2'd0: begin
				s0_c = vs_c;
				c0_c = vc_c;
			end
			2'd1: begin
				s0_c = vc_c;
				c0_c = -vs_c;
			end
			2'd2: begin
				s0_c = -vs_c;
				c0_c = -vc_c;
			end
			default: begin
				s0_c = -vc_c;
				c0_c = vs_c;
			end
		endcase
	end

	// stage 5: correction products
	logic signed [STEP_W+18:0] hc_c;
	logic signed [STEP_W+18:0] hs_c;
	logic signed [G_W+18:0]    gs_c;
	logic signed [G_W+18:0]    gc_c;
	logic signed [STEP_W+18:0] hc_s5;
	logic signed [STEP_W+18:0] hs_s5;
	logic signed [G_W+18:0]    gs_s5;
	logic signed [G_W+18:0]    gc_s5;
	samp_t                     s0_s5;
	samp_t                     c0_s5;

	assign hc_c = $signed({1'b0, h_s4}) * c0_s4;
	assign hs_c = $signed({1'b0, h_s4}) * s0_s4;
	assign gs_c = $signed({1'b0, g_s4}) * s0_s4;
	assign gc_c = $signed({1'b0, g_s4}) * c0_s4;

	// stage 6: q4.48 sums
	logic signed [SUM_W-1:0] sn_sum_c;
	logic signed [SUM_W-1:0] cs_sum_c;
	logic signed [SUM_W-1:0] sn_sum_s6;
	logic signed [SUM_W-1:0] cs_sum_s6;

	assign sn_sum_c = (SUM_W'(s0_s5) <<< 32) + SUM_W'(hc_s5) - SUM_W'(gs_s5);
	assign cs_sum_c = (SUM_W'(c0_s5) <<< 32) - SUM_W'(hs_s5) - SUM_W'(gc_s5);

	// stage 7: round half up to q16 and saturate
	function automatic samp_t round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = (v + RND_BIAS) >>> 32;
		if (r > SUM_W'(OUT_MAX)) begin
			return OUT_MAX;
		end else if (r < SUM_W'(OUT_MIN)) begin
			return OUT_MIN;
		end
		return samp_t'(r);
	endfunction

	samp_t sine_s7;
	samp_t cosine_s7;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			turn_s1 <= turn_prod_c[55:24];
		end
		if (adv[2]) begin
			quad_s2 <= quad_c;
			idx_s2  <= idx_c;
			frac_s2 <= scaled_c[31:0];
		end
		if (adv[3]) begin
			vs_s3   <= rom_mem[idx_s2];
			vc_s3   <= rom_mem[QTOP - idx_s2];
			h_s3    <= h_prod_c[32+STEP_W-1:32];
			quad_s3 <= quad_s2;
		end
		if (adv[4]) begin
			s0_s4 <= s0_c;
			c0_s4 <= c0_c;
			h_s4  <= h_s3;
			g_s4  <= h_sq_c[2*STEP_W-1:33];
		end
		if (adv[5]) begin
			hc_s5 <= hc_c;
			hs_s5 <= hs_c;
			gs_s5 <= gs_c;
			gc_s5 <= gc_c;
			s0_s5 <= s0_s4;
			c0_s5 <= c0_s4;
		end
		if (adv[6]) begin
			sn_sum_s6 <= sn_sum_c;
			cs_sum_s6 <= cs_sum_c;
		end
		if (adv[7]) begin
			sine_s7   <= round_sat(sn_sum_s6);
			cosine_s7 <= round_sat(cs_sum_s6);
		end
	end

	assign sine   = sine_s7;
	assign cosine = cosine_s7;

endmodule
